@@ rtl/core/buddy_page_allocator_top_defines.svh @@
// assertion macros for the buddy page allocator
// expects clk and rst_n in the scope of use
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bpa_pkg.sv @@
// shared constants for the buddy page allocator
// no dependencies
`default_nettype none

package bpa_pkg;

    // default pool geometry
    localparam int NUM_PAGES_DEF  = 4096;
    localparam int NUM_ORDERS_DEF = 11;

    // fixed port field widths
    localparam int ORDER_W = 4;
    localparam int PAGE_W  = 12;

    // request and status codes
    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_FREE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/buddy_page_allocator_top.sv @@
// buddy page allocator: free lists per order, page table in one single-port ram
// depends on bpa_pkg and buddy_page_allocator_top_defines.svh
`default_nettype none

// After reset the block runs a clearing pass that writes all NUM_PAGES page
// table entries (4096 by default), with in_stall high. It then takes one request
// at a time and gives exactly one result per request. All page state sits in a
// single ram with one port, so the list steps run one ram access at a time. An
// allocate searches the orders upward, unlinks the block it finds and splits it
// down, pushing each upper half onto its list after first taking that half off
// any list it is on; a free merges with its buddy while it can and then pushes the
// result. An allocate that finds no block and a rejected free end with fail status.
// A finished result waits in the output register while the next request is taken.
module buddy_page_allocator_top #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [bpa_pkg::ORDER_W-1:0] block_order,
    input  wire logic [bpa_pkg::PAGE_W-1:0]  page_index,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             status,
    output logic [bpa_pkg::PAGE_W-1:0]       result_page
);

`include "buddy_page_allocator_top_defines.svh"

    localparam int TOP     = NUM_ORDERS - 1;
    localparam int AW      = $clog2(NUM_PAGES);
    localparam int LW      = $clog2(NUM_PAGES + 1);
    localparam int OW      = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int SPAN    = 1 << TOP;
    localparam int BLOCKS  = NUM_PAGES / SPAN;
    localparam int MANAGED = BLOCKS * SPAN;
    localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

    // page table entry layout
    localparam int P_LSB = 0;
    localparam int N_LSB = LW;
    localparam int F_BIT = 2 * LW;
    localparam int O_LSB = 2 * LW + 1;
    localparam int EW    = 2 * LW + 1 + OW;

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_AL_SRCH  = 5'd2;
    localparam logic [4:0] S_AL_RD    = 5'd3;
    localparam logic [4:0] S_AL_GOT   = 5'd4;
    localparam logic [4:0] S_AL_SPLIT = 5'd5;
    localparam logic [4:0] S_AL_FIX   = 5'd6;
    localparam logic [4:0] S_FR_RD    = 5'd7;
    localparam logic [4:0] S_FR_CK    = 5'd8;
    localparam logic [4:0] S_MG_TST   = 5'd9;
    localparam logic [4:0] S_MG_CK    = 5'd10;
    localparam logic [4:0] S_MG_NXT   = 5'd11;
    localparam logic [4:0] S_FR_END   = 5'd12;
    localparam logic [4:0] S_PS_RD    = 5'd13;
    localparam logic [4:0] S_PS_CK    = 5'd14;
    localparam logic [4:0] S_PS_W     = 5'd15;
    localparam logic [4:0] S_PS_O     = 5'd16;
    localparam logic [4:0] S_UL_B     = 5'd17;
    localparam logic [4:0] S_UL_A     = 5'd18;
    localparam logic [4:0] S_UL_P     = 5'd19;
    localparam logic [4:0] S_DONE     = 5'd20;

    logic [4:0]    state_reg, state_next;
    logic [4:0]    ul_ret_reg, ul_ret_next;
    logic [4:0]    ps_ret_reg, ps_ret_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [OW-1:0] c_reg, c_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic [OW-1:0] k_reg, k_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] page_reg, page_next;
    logic [LW-1:0] mate_reg, mate_next;
    logic [LW-1:0] q_reg, q_next;
    logic [LW-1:0] u_reg, u_next;
    logic [LW-1:0] old_reg, old_next;
    logic [EW-1:0] ent_reg, ent_next;
    logic          res_status_reg, res_status_next;
    logic [LW-1:0] res_page_reg, res_page_next;
    logic          out_valid_reg;
    logic          out_status_reg;
    logic [LW-1:0] out_page_reg;

    logic [LW-1:0] head_reg [NUM_ORDERS];
    logic [LW-1:0] cnt_reg [NUM_ORDERS];

    // page table ram
    logic [EW-1:0] mem [NUM_PAGES];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] mem_addr;
    logic          rd_en;
    logic          we_ord, we_free, we_next, we_prev;
    logic [OW-1:0] wd_ord;
    logic          wd_free;
    logic [LW-1:0] wd_next, wd_prev;

    // list head and count updates
    logic          head_we;
    logic [OW-1:0] head_idx;
    logic [LW-1:0] head_val;
    logic          cnt_inc, cnt_dec;

    logic          rd_free;
    logic [OW-1:0] rd_ord;
    logic [OW-1:0] ent_ord;
    logic [LW-1:0] ent_prev, ent_next_link;
    logic [31:0]   clr32, pg32, sz32;
    logic          clr_head, free_ok, ord_big, out_free;
    logic [OW-1:0] cm1;
    logic [LW-1:0] mate_w;

    assign rd_free       = rd_data_reg[F_BIT];
    assign rd_ord        = rd_data_reg[O_LSB +: OW];
    assign ent_ord       = ent_reg[O_LSB +: OW];
    assign ent_prev      = ent_reg[P_LSB +: LW];
    assign ent_next_link = ent_reg[N_LSB +: LW];

    // clearing pass values
    assign clr32    = 32'(clr_reg);
    assign clr_head = ((clr32 & 32'(SPAN - 1)) == 32'd0) && (clr32 < 32'(MANAGED));

    // free request checks
    assign ord_big = int'(block_order) > TOP;
    assign pg32    = 32'(page_index);
    assign sz32    = 32'd1 << block_order;
    assign free_ok = !ord_big && (pg32 < 32'(NUM_PAGES))
                     && ((pg32 & (sz32 - 32'd1)) == 32'd0)
                     && ((pg32 + sz32) <= 32'(NUM_PAGES));

    assign cm1    = c_reg - OW'(1);
    assign mate_w = page_reg ^ (LW'(1) << ord_reg);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // control sequencer
    always_comb
    begin
        state_next      = state_reg;
        ul_ret_next     = ul_ret_reg;
        ps_ret_next     = ps_ret_reg;
        clr_next        = clr_reg;
        c_next          = c_reg;
        ord_next        = ord_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        page_next       = page_reg;
        mate_next       = mate_reg;
        q_next          = q_reg;
        u_next          = u_reg;
        old_next        = old_reg;
        ent_next        = ent_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        mem_addr        = '0;
        rd_en           = 1'b0;
        we_ord          = 1'b0;
        we_free         = 1'b0;
        we_next         = 1'b0;
        we_prev         = 1'b0;
        wd_ord          = '0;
        wd_free         = 1'b0;
        wd_next         = NIL;
        wd_prev         = NIL;
        head_we         = 1'b0;
        head_idx        = '0;
        head_val        = NIL;
        cnt_inc         = 1'b0;
        cnt_dec         = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                mem_addr = clr_reg;
                we_ord   = 1'b1;
                we_free  = 1'b1;
                we_next  = 1'b1;
                we_prev  = 1'b1;
                wd_ord   = clr_head ? OW'(TOP) : '0;
                wd_free  = clr_head;
                wd_prev  = (clr_head && clr32 != 32'd0) ? LW'(clr32 - 32'(SPAN)) : NIL;
                wd_next  = (clr_head && (clr32 + 32'(SPAN)) < 32'(MANAGED))
                           ? LW'(clr32 + 32'(SPAN)) : NIL;
                if (clr_reg == AW'(NUM_PAGES - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = bpa_pkg::STATUS_FAIL;
                    res_page_next   = '0;
                    ord_next        = OW'(block_order);
                    c_next          = OW'(block_order);
                    page_next       = LW'(page_index);
                    if (func == bpa_pkg::FUNC_ALLOC)
                        state_next = ord_big ? S_DONE : S_AL_SRCH;
                    else
                        state_next = free_ok ? S_FR_RD : S_DONE;
                end
            end
            // walk the orders upward for a non-empty list
            S_AL_SRCH:
            begin
                if (head_reg[c_reg] != NIL)
                begin
                    p_next     = head_reg[c_reg];
                    state_next = S_AL_RD;
                end
                else if (int'(c_reg) == TOP)
                    state_next = S_DONE;
                else
                    c_next = c_reg + OW'(1);
            end
            S_AL_RD:
            begin
                mem_addr   = AW'(p_reg);
                rd_en      = 1'b1;
                state_next = S_AL_GOT;
            end
            S_AL_GOT:
            begin
                ent_next    = rd_data_reg;
                u_next      = p_reg;
                ul_ret_next = S_AL_SPLIT;
                state_next  = S_UL_B;
            end
            // push upper halves down to the requested order
            S_AL_SPLIT:
            begin
                if (c_reg > ord_reg)
                begin
                    c_next      = cm1;
                    k_next      = cm1;
                    q_next      = p_reg + (LW'(1) << cm1);
                    ps_ret_next = S_AL_SPLIT;
                    state_next  = S_PS_RD;
                end
                else
                    state_next = S_AL_FIX;
            end
            S_AL_FIX:
            begin
                mem_addr        = AW'(p_reg);
                we_ord          = 1'b1;
                wd_ord          = ord_reg;
                res_status_next = bpa_pkg::STATUS_OK;
                res_page_next   = p_reg;
                state_next      = S_DONE;
            end
            S_FR_RD:
            begin
                mem_addr   = AW'(page_reg);
                rd_en      = 1'b1;
                state_next = S_FR_CK;
            end
            S_FR_CK:
            begin
                state_next = rd_free ? S_DONE : S_MG_TST;
            end
            // try to merge with the xor buddy
            S_MG_TST:
            begin
                if (int'(ord_reg) < TOP && mate_w < NIL)
                begin
                    mate_next  = mate_w;
                    mem_addr   = AW'(mate_w);
                    rd_en      = 1'b1;
                    state_next = S_MG_CK;
                end
                else
                begin
                    q_next      = page_reg;
                    k_next      = ord_reg;
                    ps_ret_next = S_FR_END;
                    state_next  = S_PS_RD;
                end
            end
            S_MG_CK:
            begin
                if (rd_free && rd_ord == ord_reg)
                begin
                    ent_next    = rd_data_reg;
                    u_next      = mate_reg;
                    ul_ret_next = S_MG_NXT;
                    state_next  = S_UL_B;
                end
                else
                begin
                    q_next      = page_reg;
                    k_next      = ord_reg;
                    ps_ret_next = S_FR_END;
                    state_next  = S_PS_RD;
                end
            end
            S_MG_NXT:
            begin
                page_next  = page_reg & mate_reg;
                ord_next   = ord_reg + OW'(1);
                state_next = S_MG_TST;
            end
            S_FR_END:
            begin
                res_status_next = bpa_pkg::STATUS_OK;
                res_page_next   = '0;
                state_next      = S_DONE;
            end
            // push q onto list k, first taking it off any list it is on
            S_PS_RD:
            begin
                mem_addr   = AW'(q_reg);
                rd_en      = 1'b1;
                state_next = S_PS_CK;
            end
            S_PS_CK:
            begin
                if (rd_free)
                begin
                    ent_next    = rd_data_reg;
                    u_next      = q_reg;
                    ul_ret_next = S_PS_W;
                    state_next  = S_UL_B;
                end
                else
                    state_next = S_PS_W;
            end
            S_PS_W:
            begin
                mem_addr   = AW'(q_reg);
                we_ord     = 1'b1;
                we_free    = 1'b1;
                we_next    = 1'b1;
                we_prev    = 1'b1;
                wd_ord     = k_reg;
                wd_free    = 1'b1;
                wd_next    = head_reg[k_reg];
                wd_prev    = NIL;
                head_we    = 1'b1;
                head_idx   = k_reg;
                head_val   = q_reg;
                cnt_inc    = 1'b1;
                old_next   = head_reg[k_reg];
                state_next = S_PS_O;
            end
            S_PS_O:
            begin
                if (old_reg != NIL)
                begin
                    mem_addr = AW'(old_reg);
                    we_prev  = 1'b1;
                    wd_prev  = q_reg;
                end
                state_next = ps_ret_reg;
            end
            // unlink u, whose entry is held in ent
            S_UL_B:
            begin
                if (ent_prev != NIL)
                begin
                    mem_addr = AW'(ent_prev);
                    we_next  = 1'b1;
                    wd_next  = ent_next_link;
                end
                else
                begin
                    head_we  = 1'b1;
                    head_idx = ent_ord;
                    head_val = ent_next_link;
                end
                cnt_dec    = 1'b1;
                state_next = S_UL_A;
            end
            S_UL_A:
            begin
                if (ent_next_link != NIL)
                begin
                    mem_addr = AW'(ent_next_link);
                    we_prev  = 1'b1;
                    wd_prev  = ent_prev;
                end
                state_next = S_UL_P;
            end
            S_UL_P:
            begin
                mem_addr   = AW'(u_reg);
                we_free    = 1'b1;
                we_next    = 1'b1;
                we_prev    = 1'b1;
                wd_free    = 1'b0;
                wd_next    = NIL;
                wd_prev    = NIL;
                state_next = ul_ret_reg;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // page table ram, field write enables, registered read
    always_ff @(posedge clk)
    begin
        if (we_prev)
            mem[mem_addr][P_LSB +: LW] <= wd_prev;
        if (we_next)
            mem[mem_addr][N_LSB +: LW] <= wd_next;
        if (we_free)
            mem[mem_addr][F_BIT] <= wd_free;
        if (we_ord)
            mem[mem_addr][O_LSB +: OW] <= wd_ord;
        if (rd_en)
            rd_data_reg <= mem[mem_addr];
    end

    // control state, list heads and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                head_reg[i] <= (i == TOP && BLOCKS > 0) ? '0 : NIL;
                cnt_reg[i]  <= (i == TOP) ? LW'(BLOCKS) : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (head_we)
                head_reg[head_idx] <= head_val;
            if (cnt_inc)
                cnt_reg[k_reg] <= cnt_reg[k_reg] + LW'(1);
            if (cnt_dec)
                cnt_reg[ent_ord] <= cnt_reg[ent_ord] - LW'(1);
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        ul_ret_reg     <= ul_ret_next;
        ps_ret_reg     <= ps_ret_next;
        c_reg          <= c_next;
        ord_reg        <= ord_next;
        k_reg          <= k_next;
        p_reg          <= p_next;
        page_reg       <= page_next;
        mate_reg       <= mate_next;
        q_reg          <= q_next;
        u_reg          <= u_next;
        old_reg        <= old_next;
        ent_reg        <= ent_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= res_page_reg;
        end
    end

    // result transfer port
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_page = bpa_pkg::PAGE_W'(out_page_reg);

    `BPA_ASSERT_SAME(a_ram_one_access, rd_en, !(we_ord || we_free || we_next || we_prev), "ram read and write in one cycle")
    `BPA_ASSERT_NEXT(a_result_loaded, (state_reg == S_DONE) && out_free, out_valid_reg && (state_reg == S_IDLE), "finished result not presented")
    `BPA_ASSERT_SAME(a_unlink_order, state_reg == S_UL_B, int'(ent_ord) <= TOP, "unlink of block with bad order")
    `BPA_ASSERT_SAME(a_split_range, state_reg == S_AL_SPLIT, c_reg >= ord_reg, "split went below requested order")

endmodule

`default_nettype wire
